[src/sha1sh_pkg.sv]
package sha1sh_pkg;

  // Depth of the command queue between the front end and the hash core.
  localparam int QUEUE_DEPTH_DEF = 4;

  // SHA-1 initial chaining values.
  localparam logic [31:0] H0_INIT = 32'h6745_2301;
  localparam logic [31:0] H1_INIT = 32'hefcd_ab89;
  localparam logic [31:0] H2_INIT = 32'h98ba_dcfe;
  localparam logic [31:0] H3_INIT = 32'h1032_5476;
  localparam logic [31:0] H4_INIT = 32'hc3d2_e1f0;

  // Round constants, one per group of twenty rounds.
  localparam logic [31:0] K_GROUP0 = 32'h5a82_7999;
  localparam logic [31:0] K_GROUP1 = 32'h6ed9_eba1;
  localparam logic [31:0] K_GROUP2 = 32'h8f1b_bcdc;
  localparam logic [31:0] K_GROUP3 = 32'hca62_c1d6;

  localparam logic [7:0]  PAD_BYTE   = 8'h80;
  localparam logic [5:0]  LEN_POS    = 6'd56;
  localparam logic [5:0]  BLOCK_LAST = 6'd63;
  localparam logic [6:0]  ROUND_LAST = 7'd79;
  localparam logic [2:0]  LEN_LAST   = 3'd7;

  // Largest bit count that may still take one more byte.
  localparam logic [63:0] LEN_LIMIT = 64'hffff_ffff_ffff_fff0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
    logic        too_large;
  } digest_t;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_BYTE_LAST,
    CMD_FINISH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_MSG,
    PH_PAD,
    PH_DONE
  } phase_t;

endpackage

[src/sha1sh_front.sv]
module sha1sh_front #(
  parameter int DEPTH = sha1sh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  sha1sh_pkg::item_t item,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output sha1sh_pkg::cmd_t  cmd
);
  import sha1sh_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             queue_mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  cmd_t new_cmd;
  logic keep;
  logic push;
  logic pop;

  // Items that neither carry a byte nor end the message change nothing.
  always_comb begin
    keep             = item.has_byte | item.last;
    new_cmd.data_byte = item.data_byte;
    if (!item.last) begin
      new_cmd.kind = CMD_BYTE;
    end else if (item.has_byte) begin
      new_cmd.kind = CMD_BYTE_LAST;
    end else begin
      new_cmd.kind = CMD_FINISH;
    end
  end

  assign item_ready = (count != CNT_W'(DEPTH));
  assign push       = item_valid & item_ready & keep;
  assign cmd_valid  = (count != '0);
  assign pop        = cmd_valid & cmd_ready;
  assign cmd        = queue_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/sha1sh_core.sv]
module sha1sh_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  sha1sh_pkg::cmd_t    cmd,
  output logic                digest_valid,
  input  logic                digest_ready,
  output sha1sh_pkg::digest_t digest
);
  import sha1sh_pkg::*;

  state_t st;
  state_t st_next;
  phase_t phase;

  logic [31:0] chain [5];
  logic [31:0] vars  [5];
  logic [31:0] win   [16];
  logic [23:0] word_acc;
  logic [5:0]  fill_count;
  logic [63:0] bit_length;
  logic [6:0]  round_index;
  logic        overflow_flag;
  logic        pad_first;
  logic [2:0]  len_idx;

  // Strobes from the output decode.
  logic       push;
  logic [7:0] push_byte;
  logic       count_byte;
  logic       set_flag;
  logic       start_last;
  logic       clr_pad_first;
  logic       len_push;
  logic       round_en;
  logic       add_en;
  logic       emit;

  logic        wrap;
  logic        len_full;
  logic        cmd_has_byte;
  logic        cmd_is_last;
  logic [7:0]  len_byte;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;
  logic [31:0] w_new;

  assign wrap         = (fill_count == BLOCK_LAST);
  assign len_full     = (bit_length > LEN_LIMIT);
  assign cmd_has_byte = (cmd.kind != CMD_FINISH);
  assign cmd_is_last  = (cmd.kind != CMD_BYTE);
  assign len_byte     = bit_length[{~len_idx, 3'b000} +: 8];

  // One SHA-1 round on the working variables.
  always_comb begin
    priority if (round_index < 7'd20) begin
      f_val = (vars[1] & vars[2]) | (~vars[1] & vars[3]);
      k_val = K_GROUP0;
    end else if (round_index < 7'd40) begin
      f_val = vars[1] ^ vars[2] ^ vars[3];
      k_val = K_GROUP1;
    end else if (round_index < 7'd60) begin
      f_val = (vars[1] & vars[2]) | (vars[1] & vars[3]) | (vars[2] & vars[3]);
      k_val = K_GROUP2;
    end else begin
      f_val = vars[1] ^ vars[2] ^ vars[3];
      k_val = K_GROUP3;
    end
    t_val = {vars[0][26:0], vars[0][31:27]} + f_val + vars[4] + k_val + win[0];
    w_new = win[13] ^ win[8] ^ win[2] ^ win[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  // Output decode.
  always_comb begin
    cmd_ready     = 1'b0;
    push          = 1'b0;
    push_byte     = 8'h00;
    count_byte    = 1'b0;
    set_flag      = 1'b0;
    start_last    = 1'b0;
    clr_pad_first = 1'b0;
    len_push      = 1'b0;
    round_en      = 1'b0;
    add_en        = 1'b0;
    emit          = 1'b0;
    unique case (st)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (cmd_has_byte) begin
            if (len_full) begin
              set_flag = 1'b1;
            end else begin
              push       = 1'b1;
              push_byte  = cmd.data_byte;
              count_byte = 1'b1;
            end
          end
          start_last = cmd_is_last;
        end
      end
      S_PAD: begin
        if (pad_first) begin
          push          = 1'b1;
          push_byte     = PAD_BYTE;
          clr_pad_first = 1'b1;
        end else if (fill_count != LEN_POS) begin
          push = 1'b1;
        end
      end
      S_LEN: begin
        push      = 1'b1;
        push_byte = len_byte;
        len_push  = 1'b1;
      end
      S_ROUND: round_en = 1'b1;
      S_ADD:   add_en   = 1'b1;
      S_OUT:   emit     = !digest_valid || digest_ready;
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE: begin
        if (cmd_valid) begin
          if (push && wrap) begin
            st_next = S_ROUND;
          end else if (cmd_is_last) begin
            st_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (push && wrap) begin
          st_next = S_ROUND;
        end else if (!pad_first && fill_count == LEN_POS) begin
          st_next = S_LEN;
        end
      end
      S_LEN: begin
        if (wrap) begin
          st_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (round_index == ROUND_LAST) begin
          st_next = S_ADD;
        end
      end
      S_ADD: begin
        unique case (phase)
          PH_MSG:  st_next = S_IDLE;
          PH_PAD:  st_next = S_PAD;
          PH_DONE: st_next = S_OUT;
          default: st_next = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (emit) begin
          st_next = S_IDLE;
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // Control state and chaining words.
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= S_IDLE;
      phase         <= PH_MSG;
      chain[0]      <= H0_INIT;
      chain[1]      <= H1_INIT;
      chain[2]      <= H2_INIT;
      chain[3]      <= H3_INIT;
      chain[4]      <= H4_INIT;
      fill_count    <= '0;
      bit_length    <= '0;
      round_index   <= '0;
      overflow_flag <= 1'b0;
      pad_first     <= 1'b0;
      len_idx       <= '0;
      digest_valid  <= 1'b0;
    end else begin
      st <= st_next;
      if (push) begin
        fill_count <= fill_count + 6'd1;
      end
      if (count_byte) begin
        bit_length <= bit_length + 64'd8;
      end
      if (set_flag) begin
        overflow_flag <= 1'b1;
      end
      if (start_last) begin
        pad_first <= 1'b1;
        phase     <= PH_PAD;
      end
      if (clr_pad_first) begin
        pad_first <= 1'b0;
      end
      if (len_push) begin
        len_idx <= len_idx + 3'd1;
        if (len_idx == LEN_LAST) begin
          phase <= PH_DONE;
        end
      end
      if (round_en) begin
        round_index <= (round_index == ROUND_LAST) ? 7'd0 : round_index + 7'd1;
      end
      if (add_en) begin
        for (int i = 0; i < 5; i++) begin
          chain[i] <= chain[i] + vars[i];
        end
      end
      if (emit) begin
        digest_valid  <= 1'b1;
        chain[0]      <= H0_INIT;
        chain[1]      <= H1_INIT;
        chain[2]      <= H2_INIT;
        chain[3]      <= H3_INIT;
        chain[4]      <= H4_INIT;
        bit_length    <= '0;
        overflow_flag <= 1'b0;
        phase         <= PH_MSG;
        len_idx       <= '0;
      end else if (digest_ready) begin
        digest_valid <= 1'b0;
      end
    end
  end

  // Byte packing, message schedule and working variables.
  always_ff @(posedge clk) begin
    if (push) begin
      if (fill_count[1:0] == 2'b11) begin
        for (int i = 0; i < 15; i++) begin
          win[i] <= win[i+1];
        end
        win[15] <= {word_acc, push_byte};
      end else begin
        word_acc <= {word_acc[15:0], push_byte};
      end
      if (wrap) begin
        for (int i = 0; i < 5; i++) begin
          vars[i] <= chain[i];
        end
      end
    end
    if (round_en) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
      vars[4] <= vars[3];
      vars[3] <= vars[2];
      vars[2] <= {vars[1][1:0], vars[1][31:2]};
      vars[1] <= vars[0];
      vars[0] <= t_val;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      digest.digest_word0 <= chain[0];
      digest.digest_word1 <= chain[1];
      digest.digest_word2 <= chain[2];
      digest.digest_word3 <= chain[3];
      digest.digest_word4 <= chain[4];
      digest.too_large    <= overflow_flag;
    end
  end

  // A compression only starts when the block has just filled.
  a_round_on_full_block: assert property (@(posedge clk) disable iff (rst)
    (st == S_ROUND || st == S_ADD) |-> (fill_count == '0))
    else $error("compression running on a partly filled block");

  a_round_index_idle: assert property (@(posedge clk) disable iff (rst)
    (st != S_ROUND) |-> (round_index == '0))
    else $error("round counter not cleared outside compression");

  a_len_slot: assert property (@(posedge clk) disable iff (rst)
    (st == S_LEN) |-> (fill_count[5:3] == 3'b111 && fill_count[2:0] == len_idx))
    else $error("length bytes out of place");

  a_add_after_last_round: assert property (@(posedge clk) disable iff (rst)
    (st == S_ROUND && round_index == ROUND_LAST) |=> (st == S_ADD))
    else $error("missing feed-forward after the last round");

endmodule

[src/sha1_stream_hasher.sv]
// A byte request is packed as it leaves the queue; a full block then runs the 80
// rounds and a feed-forward step in the hash core, which takes no request meanwhile.
// A last request adds the pad mark and zeros up to offset 56, a check, eight length
// bytes and a compression, with one more when padding spills into a second block,
// then loads the digest register once the previous digest has been taken.
// Reset (rst, synchronous, active high) empties the queue and restores the IVs at once.
module sha1_stream_hasher #(
  parameter int QUEUE_DEPTH = sha1sh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  sha1sh_pkg::item_t   item,
  output logic                digest_valid,
  input  logic                digest_ready,
  output sha1sh_pkg::digest_t digest
);
  import sha1sh_pkg::*;

  // The front end turns each request into a command: a byte, a byte that ends the
  // message, or a bare finish. Requests with neither a byte nor the last mark are
  // accepted and discarded there, since they change no state.
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  sha1sh_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // The hash core packs bytes into the schedule window, runs one round per cycle,
  // generates the padding and length bytes itself, and holds the finished digest in
  // an output register so the next message can start while it waits to be taken.
  sha1sh_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .digest_valid(digest_valid),
    .digest_ready(digest_ready),
    .digest      (digest)
  );

endmodule

[sim/sha1_stream_hasher_checker.sv]
module sha1_stream_hasher_checker
  import sha1sh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    item_ready,
  input  item_t   item,
  input  logic    digest_valid,
  input  logic    digest_ready,
  input  digest_t digest,
  output int      fail_count,
  output int      pending,
  output int      digests_seen
);

  localparam logic [31:0] IV_A = 32'h6745_2301;
  localparam logic [31:0] IV_B = 32'hefcd_ab89;
  localparam logic [31:0] IV_C = 32'h98ba_dcfe;
  localparam logic [31:0] IV_D = 32'h1032_5476;
  localparam logic [31:0] IV_E = 32'hc3d2_e1f0;

  localparam logic [31:0] ROUND_K0 = 32'h5a82_7999;
  localparam logic [31:0] ROUND_K1 = 32'h6ed9_eba1;
  localparam logic [31:0] ROUND_K2 = 32'h8f1b_bcdc;
  localparam logic [31:0] ROUND_K3 = 32'hca62_c1d6;

  localparam logic [7:0]  PAD_MARK      = 8'h80;
  localparam int          BLOCK_SIZE    = 64;
  localparam int          LENGTH_OFFSET = 56;
  localparam logic [63:0] BITS_CEILING  = 64'hffff_ffff_ffff_fff0;
  localparam int          REPORT_MAX    = 10;

  logic [31:0] chain[5];
  logic [7:0]  msg_block[BLOCK_SIZE];
  int          fill;
  logic [63:0] msg_bits;
  logic        bytes_dropped;
  digest_t     pending_digests[$];
  int          reported;

  task automatic restart_message();
    chain[0]      = IV_A;
    chain[1]      = IV_B;
    chain[2]      = IV_C;
    chain[3]      = IV_D;
    chain[4]      = IV_E;
    fill          = 0;
    msg_bits      = '0;
    bytes_dropped = 1'b0;
  endtask

  task automatic compress_block();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    int i, r, s;
    for (i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (r = 0; r < 80; r++) begin
      s = r & 15;
      if (r >= 16) begin
        x = w[(s + 13) & 15] ^ w[(s + 8) & 15] ^ w[(s + 2) & 15] ^ w[s];
        w[s] = {x[30:0], x[31]};
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = ROUND_K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = ROUND_K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = ROUND_K2;
      end else begin
        f = b ^ c ^ d;
        k = ROUND_K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[s];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endtask

  // Takes one accepted request; a last request queues the finished digest.
  task automatic absorb_request(input item_t req);
    digest_t d;
    int pos, i;
    if (req.has_byte) begin
      if (msg_bits > BITS_CEILING) begin
        bytes_dropped = 1'b1;
      end else begin
        msg_bits = msg_bits + 64'd8;
        msg_block[fill] = req.data_byte;
        fill = (fill + 1) % BLOCK_SIZE;
        if (fill == 0) begin
          compress_block();
        end
      end
    end
    if (req.last) begin
      pos = fill;
      msg_block[pos] = PAD_MARK;
      pos++;
      // No room left for the length: pad this block out and start another.
      if (pos > LENGTH_OFFSET) begin
        while (pos < BLOCK_SIZE) begin
          msg_block[pos] = 8'h00;
          pos++;
        end
        compress_block();
        pos = 0;
      end
      while (pos < LENGTH_OFFSET) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      for (i = 0; i < 8; i++) begin
        msg_block[BLOCK_SIZE - 1 - i] = msg_bits[8*i +: 8];
      end
      compress_block();
      d.digest_word0 = chain[0];
      d.digest_word1 = chain[1];
      d.digest_word2 = chain[2];
      d.digest_word3 = chain[3];
      d.digest_word4 = chain[4];
      d.too_large    = bytes_dropped;
      pending_digests.push_back(d);
      restart_message();
    end
  endtask

  task automatic check_digest(input digest_t got);
    digest_t want;
    if (pending_digests.size() == 0) begin
      fail_count++;
      if (reported < REPORT_MAX) begin
        $display("digest %0d arrived with none expected: %h %h %h %h %h too_large=%b",
                 digests_seen, got.digest_word0, got.digest_word1, got.digest_word2,
                 got.digest_word3, got.digest_word4, got.too_large);
      end
      reported++;
    end else begin
      want = pending_digests.pop_front();
      if (got.digest_word0 !== want.digest_word0 || got.digest_word1 !== want.digest_word1 ||
          got.digest_word2 !== want.digest_word2 || got.digest_word3 !== want.digest_word3 ||
          got.digest_word4 !== want.digest_word4 || got.too_large !== want.too_large) begin
        fail_count++;
        if (reported < REPORT_MAX) begin
          $display("digest %0d mismatch", digests_seen);
          $display("  expected %h %h %h %h %h too_large=%b", want.digest_word0,
                   want.digest_word1, want.digest_word2, want.digest_word3,
                   want.digest_word4, want.too_large);
          $display("  actual   %h %h %h %h %h too_large=%b", got.digest_word0,
                   got.digest_word1, got.digest_word2, got.digest_word3,
                   got.digest_word4, got.too_large);
        end
        reported++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_message();
      pending_digests.delete();
      fail_count   = 0;
      digests_seen = 0;
      reported     = 0;
    end else begin
      // A digest can never belong to a request taken at the same edge.
      if (digest_valid && digest_ready) begin
        check_digest(digest);
        digests_seen++;
      end
      if (item_valid && item_ready) begin
        absorb_request(item);
      end
    end
    pending = pending_digests.size();
  end

endmodule

[sim/sha1_stream_hasher_tb.sv]
module sha1_stream_hasher_tb;
  import sha1sh_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 10;
  // Requests that carry a byte or end a message; empty fillers are not counted.
  localparam int TARGET_REQUESTS = 880;
  localparam int MIN_MESSAGES    = 12;
  // The one long stall of the digest side, long enough to back up the queue.
  localparam int HOLD_CYCLES     = 2500;
  // The longest finish needs two compressions after the last request is queued;
  // the drain wait covers that with margin.
  localparam int DRAIN_CYCLES    = 400;
  // Cycles with no handshake on either channel before the run is declared hung.
  // It must exceed the long hold plus the slowest digest.
  localparam int WATCHDOG_LIMIT  = 20000;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    digest_valid;
  logic    digest_ready = 1'b0;
  digest_t digest;

  int fail_count;
  int pending;
  int digests_seen;
  int idle_cycles      = 0;
  int counted_requests = 0;
  int messages_sent    = 0;
  bit burst_mode       = 1'b0;
  bit hold_done        = 1'b0;

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  sha1_stream_hasher u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

  sha1_stream_hasher_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest),
    .fail_count   (fail_count),
    .pending      (pending),
    .digests_seen (digests_seen)
  );

  // Idle gap length: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end else begin
      return $urandom_range(20, 60);
    end
  endfunction

  // Offers one request and returns once it has been accepted. Everything is
  // driven at the falling edge; acceptance is seen at the rising edge. When no
  // gap is wanted, valid simply stays high and only the payload changes, so a
  // single assignment to item_valid is ever made in one time step.
  task automatic send_request(input logic [7:0] data, input logic with_byte,
                              input logic ends_message);
    int gap;
    gap = burst_mode ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item.data_byte <= data;
    item.has_byte  <= with_byte;
    item.last      <= ends_message;
    item_valid     <= 1'b1;
    do @(posedge clk); while (!item_ready);
    if (with_byte || ends_message) begin
      counted_requests++;
    end
  endtask

  // One whole message of random bytes. Empty filler requests are sprinkled in,
  // and the message ends either on its final byte or on a separate empty
  // request marked last.
  task automatic send_message(input int nbytes, input bit end_on_byte);
    int i;
    for (i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_request(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == nbytes - 1));
    end
    if (!end_on_byte || nbytes == 0) begin
      send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
    messages_sent++;
  endtask

  // Request side: reset, a handful of hand-picked messages, then random ones.
  initial begin
    int nbytes;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty message: a last request with no byte at all.
    send_request(8'hff, 1'b0, 1'b1);
    // The classic three-byte message, finished by the request carrying its last byte.
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    // All-ones byte, then an empty request that only closes the message.
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    // All-zeros byte that also ends its message.
    send_request(8'h00, 1'b1, 1'b1);
    // Empty fillers in the middle of a message must not add bytes.
    send_request(8'h5a, 1'b1, 1'b0);
    send_request(8'hc3, 1'b0, 1'b0);
    send_request(8'ha5, 1'b1, 1'b0);
    send_request(8'h3c, 1'b0, 1'b1);
    // A byte equal to the pad mark, then two empty messages back to back.
    send_request(8'h80, 1'b1, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b1);

    // Random messages. Lengths cluster around the places where the padding
    // changes shape: just below and above the length offset, exactly one
    // block, and the length offset in the second block.
    while (counted_requests < TARGET_REQUESTS || messages_sent < MIN_MESSAGES) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: begin
          nbytes = $urandom_range(0, 3);
        end
        1: begin
          nbytes = $urandom_range(54, 57);
        end
        2: begin
          nbytes = $urandom_range(63, 65);
        end
        3: begin
          nbytes = $urandom_range(118, 121);
        end
        4: begin
          nbytes = $urandom_range(0, 130);
        end
        default: begin
          nbytes = $urandom_range(0, 40);
        end
      endcase
      send_message(nbytes, 1'($urandom_range(0, 1)));
    end
    @(negedge clk);
    item_valid <= 1'b0;

    // Every message ended with a last request, so once the checker holds no
    // expectation the block should be quiet; watch a while for strays.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[sha1_stream_hasher] OK");
    end else begin
      $display("[sha1_stream_hasher] ERROR");
    end
    $finish;
  end

  // Digest side: random ready stretches and gaps, including long always-ready
  // stretches. Once a few digests have come through, ready is held low for a
  // long stretch while requests keep coming, so the core blocks on its output,
  // the queue fills and item_ready drops.
  initial begin
    int high_len;
    int gap;
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && digests_seen >= 3) begin
        @(negedge clk);
        digest_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end
      high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      @(negedge clk);
      digest_ready <= 1'b1;
      repeat (high_len - 1) @(negedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk);
        digest_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  end

  // Watchdog: any handshake on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (digest_valid && digest_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[sha1_stream_hasher] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

[sha1_stream_hasher.f]
src/sha1sh_pkg.sv
src/sha1sh_front.sv
src/sha1sh_core.sv
src/sha1_stream_hasher.sv
sim/sha1_stream_hasher_checker.sv
sim/sha1_stream_hasher_tb.sv
